@@ hdl/crc32m_pkg.sv @@
// crc32m_pkg: shared types and constants for the MSB-first 32-bit CRC stream.
// Holds the input, result and handshake structs and the reset polynomial.
// No dependencies.
`timescale 1ns / 1ps

package crc32m_pkg;

  localparam int unsigned CRC_W  = 32;
  localparam int unsigned BYTE_W = 8;

  // Polynomial loaded at reset (x^32 term implied)
  localparam logic [CRC_W-1:0] CRC_RESET_POLY = 32'h04C1_0DB7;

  // One input transaction
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              first_byte;
    logic              last_byte;
    logic [CRC_W-1:0]  start_value;
  } in_item_t;

  // One result transaction
  typedef struct packed {
    logic [CRC_W-1:0] crc_value;
    logic             is_final;
  } out_item_t;

  // Handshake state of the input stage, seen by the top level
  typedef struct packed {
    logic valid;
    logic ready;
  } stage_ctl_t;

endpackage

@@ hdl/crc32m_in_stage.sv @@
// crc32m_in_stage: input register of the CRC pipeline.
// Captures one transaction and holds it until the result register takes it.
// Depends on crc32m_pkg.
`timescale 1ns / 1ps

module crc32m_in_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  crc32m_pkg::in_item_t in_data,
  input  logic                 advance,
  output crc32m_pkg::stage_ctl_t ctl,
  output crc32m_pkg::in_item_t item
);
  import crc32m_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;
  logic     load;

  // Space when empty or when the held transaction leaves this cycle
  assign ctl.ready = !valid_r || advance;
  assign ctl.valid = valid_r;
  assign load      = in_valid && ctl.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_data;
    end
  end

  assign item = item_r;

endmodule

@@ hdl/crc32m_step.sv @@
// crc32m_step: one byte of MSB-first CRC division, eight shift/XOR steps.
// Purely combinational; sits between the input and result registers.
// Depends on crc32m_pkg.
`timescale 1ns / 1ps

module crc32m_step (
  input  logic [crc32m_pkg::CRC_W-1:0]  crc_in,
  input  logic [crc32m_pkg::BYTE_W-1:0] data_byte,
  input  logic [crc32m_pkg::CRC_W-1:0]  poly,
  output logic [crc32m_pkg::CRC_W-1:0]  crc_out
);
  import crc32m_pkg::*;

  // Byte enters the top bits, then one division step per bit
  always_comb begin
    logic [CRC_W-1:0] c;
    c = crc_in ^ {data_byte, {(CRC_W-BYTE_W){1'b0}}};
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ poly;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

@@ hdl/crc32_msb_first_stream.sv @@
// crc32_msb_first_stream: top of the MSB-first, non-reflected 32-bit CRC stream.
// Input register, byte CRC step, result register, running CRC and polynomial.
// Depends on crc32m_pkg, crc32m_in_stage and crc32m_step.
//
//  channel | ports                          | direction | payload
//  --------+--------------------------------+-----------+-----------------------
//  input   | in_valid, in_ready, in_data    | in        | byte, first, last, start
//  result  | out_valid, out_ready, out_data | out       | CRC, final flag
//  config  | cfg_we, cfg_wdata              | in        | generator polynomial
//
// A byte passes through the input register, then the result register, from
// which its result is taken; one byte is taken every cycle unless the result
// stalls, the rate set by the eight-step XOR chain closing the running-CRC loop.
// Reset clears both stage valids, the running CRC to zero and the polynomial
// to 0x04C10DB7. A stalled result holds while one more transaction waits in
// the input register.
`timescale 1ns / 1ps

module crc32_msb_first_stream (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  crc32m_pkg::in_item_t        in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output crc32m_pkg::out_item_t       out_data,
  input  logic                        cfg_we,
  input  logic [crc32m_pkg::CRC_W-1:0] cfg_wdata
);
  import crc32m_pkg::*;

  stage_ctl_t       s1_ctl;
  in_item_t         s1_item;
  logic             advance;
  logic [CRC_W-1:0] crc_base;
  logic [CRC_W-1:0] crc_new;

  logic [CRC_W-1:0] poly_r;
  logic [CRC_W-1:0] crc_r;
  logic [CRC_W-1:0] crc_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  out_item_t        out_data_r;

  // Input register
  crc32m_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .advance  (advance),
    .ctl      (s1_ctl),
    .item     (s1_item)
  );

  assign in_ready = s1_ctl.ready;

  // Transaction moves on when the result register is free or being emptied
  assign advance = s1_ctl.valid && (!out_valid_r || out_ready);

  // First byte restarts from the caller's start value
  assign crc_base = s1_item.first_byte ? s1_item.start_value : crc_r;

  crc32m_step u_step (
    .crc_in    (crc_base),
    .data_byte (s1_item.data_byte),
    .poly      (poly_r),
    .crc_out   (crc_new)
  );

  // Polynomial register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r <= CRC_RESET_POLY;
    end else if (cfg_we) begin
      poly_r <= cfg_wdata;
    end
  end

  // Running CRC and result valid
  always_comb begin
    crc_nxt       = crc_r;
    out_valid_nxt = out_valid_r;
    if (advance) begin
      crc_nxt       = crc_new;
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r.crc_value <= crc_new;
      out_data_r.is_final  <= s1_item.last_byte;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // A held result always matches the running CRC
  a_result_matches_crc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.crc_value == crc_r)
    else $error("result CRC differs from running CRC");

  // An accepted input transaction lands in the input register
  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> s1_ctl.valid)
    else $error("accepted transaction lost at input register");

  // A held transaction that cannot move on stays put
  a_hold_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_ctl.valid && !advance) |=> s1_ctl.valid)
    else $error("input register dropped a blocked transaction");

  // Moving a transaction on always yields a result next cycle
  a_advance_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("no result after transaction advanced");
`endif

endmodule
